>>> sv/closest_point_on_segment_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_SEGMENT_CORE_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_CORE_ASSERT_SVH

// plain property check
`define CPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define CPS_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants for the closest point on segment core.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned CoordW        = 32;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned LenW          = 67;
  localparam int unsigned NumW          = 99;
  localparam int unsigned QuotW         = 32;

  localparam logic [CfgIdxW-1:0] CFG_START_X = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_X   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_END_Y   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_END_Z   = 3'd5;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_START    = 2'd1,
    REGION_END      = 2'd2
  } region_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
  } query_t;

  typedef struct packed {
    logic signed [31:0] near_x;
    logic signed [31:0] near_y;
    logic signed [31:0] near_z;
    region_e            region;
  } near_t;

  // classified work item handed from front to back
  typedef struct packed {
    logic [2:0][QuotW-1:0] mag_d;
    logic [2:0]            neg;
    logic [LenW-1:0]       tq;
    logic [LenW-1:0]       den;
    vec3_t                 base;
    region_e               region;
  } job_t;

endpackage

>>> sv/cps_front.sv
// ----------------------------------------------------------------------------
// cps_front
// Takes query transactions, forms the dot products and classifies the region.
// ----------------------------------------------------------------------------
module cps_front
  import cps_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  query_t in_data_i,
  input  vec3_t  start_i,
  input  vec3_t  end_i,
  input  logic   pop_i,
  output logic   push_o,
  output job_t   job_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            acc;
  logic [3:0]      vld_q;

  coord_t             p [3];
  logic signed [32:0] d_q [3], v_q [3], w_q [3];
  logic signed [65:0] pdv_q [3], pdd_q [3], pvv_q [3], pww_q [3];
  logic signed [32:0] d2_q [3], d3_q [3];
  logic signed [67:0] t_q, len_q, dv_q, dw_q;
  job_t               job_d, job_q;

  logic               len_zero, t_in, near_s;
  logic signed [32:0] md [3];

  assign in_ready_o = cnt_q < CntW'(Depth);
  assign acc        = in_valid_i & in_ready_o;
  assign cnt_d      = cnt_q + CntW'(acc) - CntW'(pop_i);

  assign p[0] = in_data_i.query_x;
  assign p[1] = in_data_i.query_y;
  assign p[2] = in_data_i.query_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= {vld_q[2:0], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]   <= {end_i[i][31], end_i[i]} - {start_i[i][31], start_i[i]};
      v_q[i]   <= {p[i][31], p[i]} - {start_i[i][31], start_i[i]};
      w_q[i]   <= {p[i][31], p[i]} - {end_i[i][31], end_i[i]};
      pdv_q[i] <= d_q[i] * v_q[i];
      pdd_q[i] <= d_q[i] * d_q[i];
      pvv_q[i] <= v_q[i] * v_q[i];
      pww_q[i] <= w_q[i] * w_q[i];
      d2_q[i]  <= d_q[i];
      d3_q[i]  <= d2_q[i];
    end
    t_q   <= 68'(pdv_q[0]) + 68'(pdv_q[1]) + 68'(pdv_q[2]);
    len_q <= 68'(pdd_q[0]) + 68'(pdd_q[1]) + 68'(pdd_q[2]);
    dv_q  <= 68'(pvv_q[0]) + 68'(pvv_q[1]) + 68'(pvv_q[2]);
    dw_q  <= 68'(pww_q[0]) + 68'(pww_q[1]) + 68'(pww_q[2]);
    job_q <= job_d;
  end

  assign len_zero = len_q == '0;
  assign t_in     = !t_q[67] && (t_q[LenW-1:0] <= len_q[LenW-1:0]);
  assign near_s   = dv_q[LenW-1:0] < dw_q[LenW-1:0];

  always_comb begin
    job_d = '0;
    for (int i = 0; i < 3; i++) begin
      md[i]          = d3_q[i][32] ? -d3_q[i] : d3_q[i];
      job_d.mag_d[i] = md[i][QuotW-1:0];
      job_d.neg[i]   = d3_q[i][32];
    end
    job_d.base = start_i;
    job_d.tq   = '0;
    job_d.den  = LenW'(1);
    if (len_zero) begin
      job_d.region = REGION_START;
    end else if (t_in) begin
      job_d.region = REGION_INTERIOR;
      job_d.tq     = t_q[LenW-1:0];
      job_d.den    = len_q[LenW-1:0];
    end else if (near_s) begin
      job_d.region = REGION_START;
    end else begin
      job_d.region = REGION_END;
      job_d.base   = end_i;
    end
  end

  assign push_o = vld_q[3];
  assign job_o  = job_q;

endmodule

>>> sv/cps_queue.sv
// ----------------------------------------------------------------------------
// cps_queue
// Small FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_core_assert.svh"

module cps_queue
  import cps_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic empty_o,
  output logic full_o,
  output job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == CntW'(Depth);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `CPS_IMPLIES(a_no_push_full, full_o && !pop_i, !push_i, "push into full queue")
  `CPS_IMPLIES(a_no_pop_empty, empty_o, !pop_i, "pop from empty queue")
  `CPS_IMPLIES(a_empty_ptrs, empty_o, rd_ptr_q == wr_ptr_q, "queue pointers out of step")

endmodule

>>> sv/cps_back.sv
// ----------------------------------------------------------------------------
// cps_back
// Scales d by t over a pipelined restoring divider and forms the result.
// ----------------------------------------------------------------------------
module cps_back
  import cps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  empty_i,
  input  job_t  job_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output near_t out_data_o
);

  localparam int unsigned NDiv = QuotW;

  typedef struct packed {
    vec3_t           base;
    logic [2:0]      neg;
    logic [LenW-1:0] den;
    region_e         region;
  } side_t;

  function automatic logic [NumW-1:0] div_step(logic [LenW-1:0] rem,
                                               logic [QuotW-1:0] lo,
                                               logic [LenW-1:0] den);
    logic [LenW:0]   r2;
    logic            ge;
    logic [LenW-1:0] rn;
    r2 = {rem, lo[QuotW-1]};
    ge = r2 >= {1'b0, den};
    rn = ge ? LenW'(r2 - {1'b0, den}) : r2[LenW-1:0];
    return {rn, lo[QuotW-2:0], ge};
  endfunction

  logic en;

  logic             m_vld_q, a_vld_q, out_vld_q;
  logic [65:0]      pl_q [3];
  logic [64:0]      ph_q [3];
  side_t            m_side_q, a_side_q;
  logic [NumW-1:0]  num_q [3];

  logic [NDiv-1:0]  dvld_q;
  logic [LenW-1:0]  rem_q [NDiv][3];
  logic [QuotW-1:0] lo_q  [NDiv][3];
  side_t            dside_q [NDiv];
  logic [NumW-1:0]  step_d [NDiv][3];

  near_t            out_q, out_d;
  coord_t           res [3];
  logic [QuotW-1:0] q [3];

  assign en    = !out_vld_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q   <= 1'b0;
      a_vld_q   <= 1'b0;
      dvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q   <= !empty_i;
      a_vld_q   <= m_vld_q;
      dvld_q    <= {dvld_q[NDiv-2:0], a_vld_q};
      out_vld_q <= dvld_q[NDiv-1];
    end
  end

  always_comb begin
    for (int k = 0; k < NDiv; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          step_d[k][i] = div_step(num_q[i][NumW-1:QuotW], num_q[i][QuotW-1:0], a_side_q.den);
        end else begin
          step_d[k][i] = div_step(rem_q[k-1][i], lo_q[k-1][i], dside_q[k-1].den);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i]  <= job_i.mag_d[i] * job_i.tq[33:0];
        ph_q[i]  <= job_i.mag_d[i] * job_i.tq[LenW-1:34];
        num_q[i] <= (NumW'(ph_q[i]) << 34) + NumW'(pl_q[i]);
      end
      m_side_q.base   <= job_i.base;
      m_side_q.neg    <= job_i.neg;
      m_side_q.den    <= job_i.den;
      m_side_q.region <= job_i.region;
      a_side_q        <= m_side_q;
      for (int k = 0; k < NDiv; k++) begin
        for (int i = 0; i < 3; i++) begin
          rem_q[k][i] <= step_d[k][i][NumW-1:QuotW];
          lo_q[k][i]  <= step_d[k][i][QuotW-1:0];
        end
        dside_q[k] <= (k == 0) ? a_side_q : dside_q[k-1];
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i]   = lo_q[NDiv-1][i];
      res[i] = dside_q[NDiv-1].base[i] + (dside_q[NDiv-1].neg[i] ? (~q[i] + 1'b1) : q[i]);
    end
    out_d.near_x = res[0];
    out_d.near_y = res[1];
    out_d.near_z = res[2];
    out_d.region = dside_q[NDiv-1].region;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/closest_point_on_segment_core.sv
// ----------------------------------------------------------------------------
// closest_point_on_segment_core
// Nearest point on a configured 3D segment to each query point, Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                payload
//  in       in   in_valid_i / in_ready_o  query_t  in_data_i
//  out      out  out_valid_o / out_ready_i near_t  out_data_o
//  cfg      in   cfg_we_i                 cfg_idx_i, cfg_data_i
//
//  One transaction per cycle sustained while the output is not stalled; the
//  path runs through the 4-stage front, the 2-stage scaling multiply and the 32-stage divider.
//  rst_ni clears control state and the segment configuration only; no clearing pass.
//  A stalled output freezes the back pipeline; the front keeps accepting
//  until the job queue credit runs out.
// ----------------------------------------------------------------------------
module closest_point_on_segment_core
  import cps_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  query_t             in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output near_t              out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i
);

  vec3_t start_q, end_q;
  logic  push, pop, empty, full;
  job_t  fjob, qjob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      end_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_X: start_q[0] <= cfg_data_i;
        CFG_START_Y: start_q[1] <= cfg_data_i;
        CFG_START_Z: start_q[2] <= cfg_data_i;
        CFG_END_X:   end_q[0]   <= cfg_data_i;
        CFG_END_Y:   end_q[1]   <= cfg_data_i;
        CFG_END_Z:   end_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cps_front #(.Depth(QueueDepth)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .start_i (start_q),
    .end_i   (end_q),
    .pop_i   (pop),
    .push_o  (push),
    .job_o   (fjob)
  );

  cps_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (fjob),
    .pop_i   (pop),
    .empty_o (empty),
    .full_o  (full),
    .job_o   (qjob)
  );

  cps_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i (empty),
    .job_i   (qjob),
    .pop_o   (pop),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule
